// File: src/ffws_pkg.sv
// ============================================================================
// ffws_pkg
// Shared constants, register codes, row event flags and helpers for the
// floor free window selector.
// ============================================================================
package ffws_pkg;

    // default sizing of the top level
    localparam int NUM_WINDOWS_DEF    = 5;
    localparam int MAX_ROW_LENGTH_DEF = 512;
    localparam int MAX_ROWS_DEF       = 1024;

    // fixed field widths
    localparam int LABEL_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int THR_W      = 10;
    localparam int SCAN_W     = 10;
    localparam int RESULT_W   = 4;

    // candidate floor labels (label 3 means no cluster)
    localparam int NUM_CAND = 3;

    // depth of the row event queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_SCAN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_ROWS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_THRESH = 3'd4;

    // reset values of the registers
    localparam int FRAME_ROWS_RST  = 520;
    localparam int ROW_LENGTH_RST  = 120;
    localparam int FLOOR_SCAN_RST  = 5;
    localparam int WINDOW_ROWS_RST = 104;
    localparam int THRESH_RST      = 0;

    // per-row control carried from front to back
    typedef struct packed {
        logic                win_close;
        logic                frame_end;
        logic [LABEL_W-1:0]  floor_label;
    } t_row_flags;

    localparam int FLAGS_W = $bits(t_row_flags);

    // clamp an elaboration or register value into lo..hi
    function automatic int clamp_range(input int v, input int lo, input int hi);
        int r;
        r = v;
        if (v < lo) r = lo;
        else if (v > hi) r = hi;
        return r;
    endfunction

endpackage

// File: src/ffws_queue.sv
// ============================================================================
// ffws_queue
// Small flop-based FIFO that holds finished row events between the front
// and the back; push and pop may happen in the same cycle.
// ============================================================================
module ffws_queue import ffws_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;

    logic [AW-1:0]    n_wr_ptr;
    logic [AW-1:0]    n_rd_ptr;

    // advance pointers with wrap at the depth
    always_comb begin
        n_wr_ptr = (32'(r_wr_ptr) == DEPTH - 1) ? '0 : r_wr_ptr + AW'(1);
        n_rd_ptr = (32'(r_rd_ptr) == DEPTH - 1) ? '0 : r_rd_ptr + AW'(1);
    end

    assign o_full  = (32'(r_count) == DEPTH);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // pointer and occupancy control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= n_wr_ptr;
            if (i_pop)  r_rd_ptr <= n_rd_ptr;
            if (i_push && !i_pop)      r_count <= r_count + (AW+1)'(1);
            else if (!i_push && i_pop) r_count <= r_count - (AW+1)'(1);
        end
    end

    // store entries
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

// File: src/ffws_front.sv
// ============================================================================
// ffws_front
// Label intake: tracks column, row and window position, the floor vote and
// the first mismatch per candidate, and emits one event per finished row.
// ============================================================================
module ffws_front import ffws_pkg::*; #(
    parameter int NUM_WINDOWS    = NUM_WINDOWS_DEF,
    parameter int MAX_ROW_LENGTH = MAX_ROW_LENGTH_DEF,
    parameter int MAX_ROWS       = MAX_ROWS_DEF,
    localparam int LW  = $clog2(MAX_ROW_LENGTH + 1),
    localparam int CW  = $clog2(MAX_ROW_LENGTH),
    localparam int RCW = $clog2(MAX_ROWS + 1),
    localparam int RW  = $clog2(MAX_ROWS),
    localparam int WNW = $clog2(NUM_WINDOWS + 1),
    localparam int EW  = FLAGS_W + WNW + NUM_CAND * LW
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [LABEL_W-1:0] i_label,
    input  logic [LW-1:0]      i_len,
    input  logic [SCAN_W-1:0]  i_scan,
    input  logic [RCW-1:0]     i_rows,
    input  logic [RCW-1:0]     i_wrows,
    input  logic               i_q_full,
    output logic               o_push,
    output logic [EW-1:0]      o_evt
);

    localparam int VW = $clog2(MAX_ROWS * MAX_ROW_LENGTH + 1);

    logic [CW-1:0]       r_col;
    logic [RW-1:0]       r_row;
    logic [RW-1:0]       r_riw;
    logic [WNW-1:0]      r_wnum;
    logic [NUM_CAND-1:0] r_seen;
    logic [CW-1:0]       r_fm   [NUM_CAND];
    logic [VW-1:0]       r_vote [NUM_CAND];

    logic [NUM_CAND-1:0] n_seen;
    logic [CW-1:0]       n_fm   [NUM_CAND];
    logic [VW-1:0]       n_vote [NUM_CAND];
    logic [LW-1:0]       free_len [NUM_CAND];

    logic                accept;
    logic                row_end;
    logic                frame_end;
    logic                win_valid;
    logic                win_close;
    logic                vote_en;
    logic [LABEL_W-1:0]  floor_sel;
    t_row_flags          flags;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;

    // classify the current label against row, frame and window limits
    always_comb begin
        row_end   = (32'(r_col) + 1 >= 32'(i_len));
        frame_end = (32'(r_row) + 1 >= 32'(i_rows));
        win_valid = (32'(r_wnum) < NUM_WINDOWS);
        win_close = win_valid && (32'(r_riw) + 1 >= 32'(i_wrows));
        vote_en   = (32'(r_col) < 32'(i_scan)) && (32'(r_col) < 32'(i_len));

        for (int c = 0; c < NUM_CAND; c++) begin
            n_seen[c] = r_seen[c] || (i_label != LABEL_W'(c));
            n_fm[c]   = (!r_seen[c] && (i_label != LABEL_W'(c))) ? r_col : r_fm[c];
            free_len[c] = (n_seen[c] && (32'(n_fm[c]) < 32'(i_len))) ?
                          LW'(n_fm[c]) : i_len;
            n_vote[c] = r_vote[c] + VW'(vote_en && (i_label == LABEL_W'(c)));
        end

        // most votes wins, ties go to 1, then 2, then 0
        if (n_vote[1] >= n_vote[0] && n_vote[1] >= n_vote[2])
            floor_sel = LABEL_W'(1);
        else if (n_vote[2] >= n_vote[1] && n_vote[2] >= n_vote[0])
            floor_sel = LABEL_W'(2);
        else
            floor_sel = LABEL_W'(0);

        flags.win_close   = win_close;
        flags.frame_end   = frame_end;
        flags.floor_label = floor_sel;
    end

    assign o_push = accept && row_end;
    assign o_evt  = {flags, r_wnum, free_len[2], free_len[1], free_len[0]};

    // position counters, vote and mismatch tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_riw  <= '0;
            r_wnum <= '0;
            r_seen <= '0;
            for (int c = 0; c < NUM_CAND; c++) r_vote[c] <= '0;
        end else if (accept) begin
            if (!row_end) begin
                r_col  <= r_col + CW'(1);
                r_seen <= n_seen;
                r_vote <= n_vote;
            end else begin
                r_col  <= '0;
                r_seen <= '0;
                if (frame_end) begin
                    r_row  <= '0;
                    r_riw  <= '0;
                    r_wnum <= '0;
                    for (int c = 0; c < NUM_CAND; c++) r_vote[c] <= '0;
                end else begin
                    r_row  <= r_row + RW'(1);
                    r_vote <= n_vote;
                    if (win_close) begin
                        r_riw  <= '0;
                        r_wnum <= r_wnum + WNW'(1);
                    end else if (win_valid) begin
                        r_riw  <= r_riw + RW'(1);
                    end
                end
            end
        end
    end

    // mismatch positions are only read once their seen bit is set
    always_ff @(posedge i_clk) begin
        if (accept) r_fm <= n_fm;
    end

endmodule

// File: src/ffws_back.sv
// ============================================================================
// ffws_back
// Row event processing: accumulates window sums per candidate, keeps the
// running best window, and at frame end picks the floor candidate's result.
// ============================================================================
module ffws_back import ffws_pkg::*; #(
    parameter int NUM_WINDOWS    = NUM_WINDOWS_DEF,
    parameter int MAX_ROW_LENGTH = MAX_ROW_LENGTH_DEF,
    parameter int MAX_ROWS       = MAX_ROWS_DEF,
    localparam int LW  = $clog2(MAX_ROW_LENGTH + 1),
    localparam int RCW = $clog2(MAX_ROWS + 1),
    localparam int WNW = $clog2(NUM_WINDOWS + 1),
    localparam int EW  = FLAGS_W + WNW + NUM_CAND * LW
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_evt_valid,
    input  logic [EW-1:0]              i_evt,
    output logic                       o_evt_pop,
    input  logic [THR_W-1:0]           i_thr,
    input  logic [RCW-1:0]             i_wrows,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [RESULT_W-1:0] o_best_window,
    output logic                       o_turn_around,
    output logic [LABEL_W-1:0]         o_floor_label
);

    localparam int SW     = $clog2(MAX_ROWS * MAX_ROW_LENGTH + 1);
    localparam int PW     = THR_W + RCW;
    localparam int CMPW   = (SW > PW) ? SW : PW;
    localparam int CENTRE = (NUM_WINDOWS - 1) / 2;

    logic [SW-1:0]  r_acc  [NUM_CAND];
    logic [SW-1:0]  r_best [NUM_CAND];
    logic [WNW-1:0] r_bidx [NUM_CAND];

    logic [SW-1:0]  n_acc  [NUM_CAND];
    logic [SW-1:0]  n_best [NUM_CAND];
    logic [WNW-1:0] n_bidx [NUM_CAND];

    logic [PW-1:0]  r_prod;

    logic                r_s1_valid;
    logic [SW-1:0]       r_s1_sum;
    logic [WNW-1:0]      r_s1_idx;
    logic [LABEL_W-1:0]  r_s1_floor;

    logic                       r_out_valid;
    logic signed [RESULT_W-1:0] r_out_best;
    logic                       r_out_turn;
    logic [LABEL_W-1:0]         r_out_floor;

    t_row_flags     flags;
    logic [WNW-1:0] wnum;
    logic           win_valid;
    logic           s1_move;
    logic           s1_free;
    logic [SW-1:0]  sel_sum;
    logic [WNW-1:0] sel_idx;

    // unpack the row event
    assign flags     = t_row_flags'(i_evt[NUM_CAND*LW+WNW +: FLAGS_W]);
    assign wnum      = i_evt[NUM_CAND*LW +: WNW];
    assign win_valid = (32'(wnum) < NUM_WINDOWS);

    // result pipe handshake
    assign s1_move   = r_s1_valid && (!r_out_valid || i_ready);
    assign s1_free   = !r_s1_valid || s1_move;
    assign o_evt_pop = i_evt_valid && (!flags.frame_end || s1_free);

    // add the row's free length and compare against the running best
    always_comb begin
        for (int c = 0; c < NUM_CAND; c++) begin
            n_acc[c] = r_acc[c] + (win_valid ? SW'(i_evt[c*LW +: LW]) : SW'(0));
            if ((flags.win_close || flags.frame_end) && (n_acc[c] > r_best[c])) begin
                n_best[c] = n_acc[c];
                n_bidx[c] = wnum;
            end else begin
                n_best[c] = r_best[c];
                n_bidx[c] = r_bidx[c];
            end
        end

        unique case (flags.floor_label)
            LABEL_W'(1): begin
                sel_sum = n_best[1];
                sel_idx = n_bidx[1];
            end
            LABEL_W'(2): begin
                sel_sum = n_best[2];
                sel_idx = n_bidx[2];
            end
            default: begin
                sel_sum = n_best[0];
                sel_idx = n_bidx[0];
            end
        endcase
    end

    // window accumulators and running best per candidate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CAND; c++) begin
                r_acc[c]  <= '0;
                r_best[c] <= '0;
                r_bidx[c] <= '0;
            end
        end else if (o_evt_pop) begin
            for (int c = 0; c < NUM_CAND; c++) begin
                if (flags.frame_end) begin
                    r_acc[c]  <= '0;
                    r_best[c] <= '0;
                    r_bidx[c] <= '0;
                end else begin
                    r_acc[c]  <= flags.win_close ? SW'(0) : n_acc[c];
                    r_best[c] <= n_best[c];
                    r_bidx[c] <= n_bidx[c];
                end
            end
        end
    end

    // threshold scaled to a window sum
    always_ff @(posedge i_clk) begin
        r_prod <= PW'(i_thr) * PW'(i_wrows);
    end

    // result pipe valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_evt_pop && flags.frame_end) r_s1_valid <= 1'b1;
            else if (s1_move)                 r_s1_valid <= 1'b0;
            if (s1_move)                      r_out_valid <= 1'b1;
            else if (i_ready)                 r_out_valid <= 1'b0;
        end
    end

    // result pipe payload
    always_ff @(posedge i_clk) begin
        if (o_evt_pop && flags.frame_end) begin
            r_s1_sum   <= sel_sum;
            r_s1_idx   <= sel_idx;
            r_s1_floor <= flags.floor_label;
        end
        if (s1_move) begin
            r_out_best  <= RESULT_W'(r_s1_idx) - RESULT_W'(CENTRE);
            r_out_turn  <= (CMPW'(r_s1_sum) < CMPW'(r_prod));
            r_out_floor <= r_s1_floor;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_best_window = r_out_best;
    assign o_turn_around = r_out_turn;
    assign o_floor_label = r_out_floor;

endmodule

// File: src/floor_free_window_select.sv
// ============================================================================
// floor_free_window_select
// Per-frame floor label vote and free-window selection over a label stream.
// ============================================================================
// Takes one cluster label per clock, row by row, and delivers one result per
// frame: the floor label, the best window index relative to the centre window
// and the turn-around flag. The front end accepts a label every cycle; each
// finished row becomes an event in a four-entry queue that the back end
// drains at one event per cycle unless a frame-end event waits on a held
// result, so input stalls only when the result register is held and the
// queue has filled. The result is registered in the selection stage, then
// the output register. Configuration writes take effect on the next label.
// ============================================================================
module floor_free_window_select import ffws_pkg::*; #(
    parameter int NUM_WINDOWS    = NUM_WINDOWS_DEF,
    parameter int MAX_ROW_LENGTH = MAX_ROW_LENGTH_DEF,
    parameter int MAX_ROWS       = MAX_ROWS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [LABEL_W-1:0]         i_label,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [RESULT_W-1:0] o_best_window,
    output logic                       o_turn_around,
    output logic [LABEL_W-1:0]         o_floor_label,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int LW  = $clog2(MAX_ROW_LENGTH + 1);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int WNW = $clog2(NUM_WINDOWS + 1);
    localparam int EW  = FLAGS_W + WNW + NUM_CAND * LW;

    logic [RCW-1:0]    r_rows;
    logic [LW-1:0]     r_len;
    logic [SCAN_W-1:0] r_scan;
    logic [RCW-1:0]    r_wrows;
    logic [THR_W-1:0]  r_thr;

    logic          q_full;
    logic          q_push;
    logic          q_valid;
    logic          q_pop;
    logic [EW-1:0] q_wdata;
    logic [EW-1:0] q_rdata;

    // configuration registers; frame rows, row length and window rows are stored clamped to their legal range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= RCW'(clamp_range(FRAME_ROWS_RST, 1, MAX_ROWS));
            r_len   <= LW'(clamp_range(ROW_LENGTH_RST, 1, MAX_ROW_LENGTH));
            r_scan  <= SCAN_W'(FLOOR_SCAN_RST);
            r_wrows <= RCW'(clamp_range(WINDOW_ROWS_RST, 1, MAX_ROWS));
            r_thr   <= THR_W'(THRESH_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FRAME_ROWS:
                    r_rows <= RCW'(clamp_range(int'(i_cfg_data), 1, MAX_ROWS));
                REG_ROW_LENGTH:
                    r_len <= LW'(clamp_range(int'(i_cfg_data[9:0]), 1, MAX_ROW_LENGTH));
                REG_FLOOR_SCAN:
                    r_scan <= i_cfg_data[SCAN_W-1:0];
                REG_WINDOW_ROWS:
                    r_wrows <= RCW'(clamp_range(int'(i_cfg_data), 1, MAX_ROWS));
                REG_WINDOW_THRESH:
                    r_thr <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    ffws_front #(
        .NUM_WINDOWS    (NUM_WINDOWS),
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
        .MAX_ROWS       (MAX_ROWS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_label  (i_label),
        .i_len    (r_len),
        .i_scan   (r_scan),
        .i_rows   (r_rows),
        .i_wrows  (r_wrows),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_evt    (q_wdata)
    );

    ffws_queue #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    ffws_back #(
        .NUM_WINDOWS    (NUM_WINDOWS),
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
        .MAX_ROWS       (MAX_ROWS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_evt_valid   (q_valid),
        .i_evt         (q_rdata),
        .o_evt_pop     (q_pop),
        .i_thr         (r_thr),
        .i_wrows       (r_wrows),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_best_window (o_best_window),
        .o_turn_around (o_turn_around),
        .o_floor_label (o_floor_label)
    );

    // no result is pending right after reset
    a_no_result_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

    // the floor is always one of the three clusters
    a_floor_is_cluster: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_floor_label != 2'd3))
        else $error("floor label is the no-cluster code");

    // the reported window lies within the window range around the centre
    a_window_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (int'(o_best_window) >= -((NUM_WINDOWS - 1) / 2)) &&
                    (int'(o_best_window) <= NUM_WINDOWS - 1 - (NUM_WINDOWS - 1) / 2))
        else $error("best window outside the window range");

    // a zero threshold can never ask for a turn-around
    a_zero_thr_no_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_thr == '0)) |-> !o_turn_around)
        else $error("turn-around raised with zero threshold");

endmodule
